FILE: hdl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion unit.
package rmq_pkg;

    localparam int W = 16;
    localparam int F = W - 2;
    // radicand: 1 + up to three entries, W+2 bits signed
    localparam int RW = W + 2;
    // sqrt argument rad << F, unsigned
    localparam int SAW = RW + F;
    // root width
    localparam int ROW = (SAW + 1) / 2;
    // numerator: difference or sum of two entries
    localparam int NW = W + 1;
    // dividend magnitude (mag << F) + s/2
    localparam int DW = NW + F + 1;
    // divisor s = 2*root
    localparam int SW = ROW + 1;
    // quotient bits kept: enough to detect saturation
    localparam int QW = W + 1;

    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

    typedef struct packed {
        logic signed [W-1:0] m00;
        logic signed [W-1:0] m01;
        logic signed [W-1:0] m02;
        logic signed [W-1:0] m10;
        logic signed [W-1:0] m11;
        logic signed [W-1:0] m12;
        logic signed [W-1:0] m20;
        logic signed [W-1:0] m21;
        logic signed [W-1:0] m22;
    } t_in;

    typedef struct packed {
        logic signed [W-1:0] qw;
        logic signed [W-1:0] qx;
        logic signed [W-1:0] qy;
        logic signed [W-1:0] qz;
        logic [1:0]          branch_taken;
        logic                not_rotation;
    } t_out;

    // per-item side information carried along the pipe
    typedef struct packed {
        logic [1:0]          br;
        logic                bad;
        logic signed [NW-1:0] n0;   // lands in qx / qy / qx / qx for trace / X / Y / Z
        logic signed [NW-1:0] n1;
        logic signed [NW-1:0] n2;
    } t_side;

endpackage

FILE: hdl/rotation_matrix_to_quaternion_unit.sv
// Top level: rotation matrix to unit quaternion, fully pipelined.
// Takes one matrix per clock and returns one quaternion per clock while the pipe
// is not halted. Stages: a front stage, one stage per square root bit, one per
// quotient bit, then the output register; the whole pipe advances together
// and halts only when the output register holds an untaken result.
module rotation_matrix_to_quaternion_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rmq_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output rmq_pkg::t_out  o_data
);
    import rmq_pkg::*;

    localparam int LAT = 1 + ROW + QW;

    logic en;
    logic [LAT-1:0] r_vld;
    logic [SAW-1:0] sq_arg;
    t_side side1, side2;
    logic [ROW-1:0] root;
    logic signed [W-1:0] q0, q1, q2;
    t_side r_sd [QW+1];
    logic [ROW-1:0] r_rt [QW+1];
    t_out r_out, n_out;
    logic r_ov;
    logic signed [W-1:0] diag, z0, z1, z2;

    assign en      = !r_ov || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
            r_ov  <= r_vld[LAT-1];
        end
    end

    rmq_front u_front (.i_clk, .i_en(en), .i_in(i_data), .o_sq_arg(sq_arg), .o_side(side1));
    rmq_sqrt  u_sqrt  (.i_clk, .i_en(en), .i_arg(sq_arg), .i_side(side1),
                       .o_root(root), .o_side(side2));

    always_comb begin
        r_sd[0] = side2;
        r_rt[0] = root;
    end
    for (genvar k = 0; k < QW; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sd[k+1] <= r_sd[k];
                r_rt[k+1] <= r_rt[k];
            end
        end
    end

    rmq_div u_d0 (.i_clk, .i_en(en), .i_num(side2.n0), .i_den({root, 1'b0}), .o_q(q0));
    rmq_div u_d1 (.i_clk, .i_en(en), .i_num(side2.n1), .i_den({root, 1'b0}), .o_q(q1));
    rmq_div u_d2 (.i_clk, .i_en(en), .i_num(side2.n2), .i_den({root, 1'b0}), .o_q(q2));

    always_comb begin
        diag = W'(r_rt[QW] >> 1);
        z0   = r_sd[QW].bad ? '0 : q0;
        z1   = r_sd[QW].bad ? '0 : q1;
        z2   = r_sd[QW].bad ? '0 : q2;
        if (r_sd[QW].bad) diag = '0;
        n_out.branch_taken = r_sd[QW].br;
        n_out.not_rotation = r_sd[QW].bad;
        case (r_sd[QW].br)
            BR_TRACE: begin
                n_out.qw = diag; n_out.qx = z0; n_out.qy = z1; n_out.qz = z2;
            end
            BR_X: begin
                n_out.qx = diag; n_out.qy = z0; n_out.qz = z1; n_out.qw = z2;
            end
            BR_Y: begin
                n_out.qx = z0; n_out.qy = diag; n_out.qz = z1; n_out.qw = z2;
            end
            default: begin
                n_out.qx = z0; n_out.qy = z1; n_out.qz = diag; n_out.qw = z2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) r_out <= n_out;
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;
endmodule

FILE: hdl/rmq_front.sv
// Branch selection, radicand and off-diagonal numerators (one register stage).
module rmq_front (
    input  logic             i_clk,
    input  logic             i_en,
    input  rmq_pkg::t_in     i_in,
    output logic [rmq_pkg::SAW-1:0] o_sq_arg,
    output rmq_pkg::t_side   o_side
);
    import rmq_pkg::*;

    logic signed [RW-1:0] a00, a11, a22, tr, rad;
    logic [1:0] br;
    logic signed [NW-1:0] d21, d02, d10, s10, s02, s21;
    t_side n_side;
    logic [SAW-1:0] r_arg;
    t_side r_side;

    always_comb begin
        a00 = RW'(i_in.m00);
        a11 = RW'(i_in.m11);
        a22 = RW'(i_in.m22);
        tr  = a00 + a11 + a22;
        d21 = NW'(i_in.m21) - NW'(i_in.m12);
        d02 = NW'(i_in.m02) - NW'(i_in.m20);
        d10 = NW'(i_in.m10) - NW'(i_in.m01);
        s10 = NW'(i_in.m10) + NW'(i_in.m01);
        s02 = NW'(i_in.m02) + NW'(i_in.m20);
        s21 = NW'(i_in.m21) + NW'(i_in.m12);
        if (tr > 0) begin
            br  = BR_TRACE;
            rad = (RW'(1) <<< F) + tr;
        end else if (a00 > a11 && a00 > a22) begin
            br  = BR_X;
            rad = (RW'(1) <<< F) + a00 - a11 - a22;
        end else if (a11 > a22) begin
            br  = BR_Y;
            rad = (RW'(1) <<< F) + a11 - a00 - a22;
        end else begin
            br  = BR_Z;
            rad = (RW'(1) <<< F) + a22 - a00 - a11;
        end
        n_side.br  = br;
        n_side.bad = (rad <= 0);
        // n0..n2: numerators of the three quotients, in slot order skipping the diagonal
        case (br)
            BR_TRACE: begin n_side.n0 = d21; n_side.n1 = d02; n_side.n2 = d10; end
            BR_X:     begin n_side.n0 = s10; n_side.n1 = s02; n_side.n2 = d21; end
            BR_Y:     begin n_side.n0 = s10; n_side.n1 = s21; n_side.n2 = d02; end
            default:  begin n_side.n0 = s02; n_side.n1 = s21; n_side.n2 = d10; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_arg  <= n_side.bad ? '0 : (SAW'(unsigned'(rad)) << F);
            r_side <= n_side;
        end
    end

    assign o_sq_arg = r_arg;
    assign o_side   = r_side;
endmodule

FILE: hdl/rmq_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module rmq_sqrt (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [rmq_pkg::SAW-1:0] i_arg,
    input  rmq_pkg::t_side          i_side,
    output logic [rmq_pkg::ROW-1:0] o_root,
    output rmq_pkg::t_side          o_side
);
    import rmq_pkg::*;

    // restoring digit-by-digit: stage k decides root bit ROW-1-k
    logic [2*ROW-1:0] r_rem  [ROW+1];
    logic [ROW-1:0]   r_res  [ROW+1];
    t_side            r_sd   [ROW+1];

    always_comb begin
        r_rem[0] = (2*ROW)'(i_arg);
        r_res[0] = '0;
        r_sd[0]  = i_side;
    end

    for (genvar k = 0; k < ROW; k++) begin : g_st
        localparam int B = ROW - 1 - k;
        logic [2*ROW-1:0] trial;
        logic [2*ROW-1:0] q_rem;
        logic [ROW-1:0]   q_res;
        always_comb begin
            trial = ((2*ROW)'(r_res[k]) << (B + 1)) | ((2*ROW)'(1) << (2 * B));
            if (r_rem[k] >= trial) begin
                q_rem = r_rem[k] - trial;
                q_res = r_res[k] | (ROW'(1) << B);
            end else begin
                q_rem = r_rem[k];
                q_res = r_res[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= q_rem;
                r_res[k+1] <= q_res;
                r_sd[k+1]  <= r_sd[k];
            end
        end
    end

    assign o_root = r_res[ROW];
    assign o_side = r_sd[ROW];
endmodule

FILE: hdl/rmq_div.sv
// Pipelined restoring divider: rounded signed quotient, saturated to W bits.
module rmq_div (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [rmq_pkg::NW-1:0] i_num,
    input  logic [rmq_pkg::SW-1:0]     i_den,
    output logic signed [rmq_pkg::W-1:0]  o_q
);
    import rmq_pkg::*;

    localparam int PW = SW + 1;
    logic [DW-1:0] r_n   [QW+1];
    logic [PW-1:0] r_p   [QW+1];
    logic [SW-1:0] r_d   [QW+1];
    logic          r_neg [QW+1];
    logic [NW-1:0] mag;

    // high part of the dividend above the quotient bits is the starting remainder;
    // it is below the divisor whenever the quotient fits in QW bits
    always_comb begin
        mag      = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
        r_n[0]   = (DW'(mag) << F) + DW'(i_den >> 1);
        r_p[0]   = PW'(r_n[0] >> QW);
        r_d[0]   = i_den;
        r_neg[0] = i_num[NW-1];
    end

    // quotient magnitude is small; only low QW bits plus an overflow flag matter
    logic r_ovf [QW+1];
    logic ovf0;
    always_comb begin
        ovf0     = (r_d[0] == '0) || ((r_n[0] >> QW) >= DW'(r_d[0]));
        r_ovf[0] = ovf0;
    end

    for (genvar k = 0; k < QW; k++) begin : g_st
        localparam int B = QW - 1 - k;
        logic [PW-1:0] t;
        logic [PW-1:0] q_p;
        logic          q_bit;
        always_comb begin
            t     = (r_p[k] << 1) | PW'(r_n[k][B]);
            q_bit = (t >= PW'(r_d[k]));
            q_p   = q_bit ? t - PW'(r_d[k]) : t;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[k+1]   <= q_p;
                r_d[k+1]   <= r_d[k];
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
                r_n[k+1]   <= {r_n[k][DW-1:QW], r_n[k][QW-1:0]} & ~(DW'(1) << B)
                              | (DW'(q_bit) << B);
            end
        end
    end

    logic [QW-1:0] qmag;
    logic [W:0]    lim;
    always_comb begin
        qmag = r_n[QW][QW-1:0];
        lim  = (W+1)'(1) << (W - 1);
        if (r_ovf[QW] || (W+1)'(qmag) >= lim)
            o_q = r_neg[QW] ? -$signed(W'(lim)) : W'(lim - 1);
        else
            o_q = r_neg[QW] ? -$signed(W'(qmag)) : $signed(W'(qmag));
    end
endmodule

FILE: hdl/rmq_checker.sv
// Port-level checks for the quaternion unit, bound to the top level.
module rmq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input rmq_pkg::t_out o_data
);
    import rmq_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("output not held");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready) else $error("stalled with empty output");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.not_rotation |-> o_data.qw == 0 && o_data.qx == 0
        && o_data.qy == 0 && o_data.qz == 0) else $error("bad matrix not zeroed");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("valid after reset");
endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_chk (
    .i_clk, .i_rst_n, .o_ready, .o_valid, .i_ready, .o_data
);
